FILE: hw/rtl/lcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Luhn card classifier package
// Widths, result codes, control bundles and the digit doubling function that
// are shared by the classifier modules and its channel interfaces.
// ----------------------------------------------------------------------------
package lcc_pkg;

   localparam int CARD_W             = 63;
   localparam int DIGIT_COUNT_W      = 5;
   localparam int BRAND_W            = 2;
   localparam int DEFAULT_MAX_DIGITS = 19;
   localparam int STEP_W             = $clog2(CARD_W);

   localparam logic [BRAND_W-1:0] BRAND_NONE     = 2'd0;
   localparam logic [BRAND_W-1:0] BRAND_PREFIX4  = 2'd1;
   localparam logic [BRAND_W-1:0] BRAND_PREFIX3X = 2'd2;
   localparam logic [BRAND_W-1:0] BRAND_PREFIX5X = 2'd3;

   // Control of the binary to decimal shift unit.
   typedef struct packed {
      logic load;
      logic shift;
      logic rotate;
   } dab_ctrl_type;

   // Control of the digit accumulator.
   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctrl_type;

   // A doubled digit with its two decimal digits added together.
   function automatic logic [3:0] luhn_double(input logic [3:0] digit);
      logic [4:0] dbl;
      dbl = {digit, 1'b0};
      if (dbl >= 5'd10) begin
         dbl = dbl - 5'd9;
      end
      return dbl[3:0];
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lcc_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Luhn card classifier channels
// Valid/ready interfaces for the request and the result channel.
// ----------------------------------------------------------------------------
interface lcc_req_if;
   import lcc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CARD_W-1:0] pan;

   modport source (output valid, output pan, input ready);
   modport sink   (input valid, input pan, output ready);
endinterface

interface lcc_rsp_if;
   import lcc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [BRAND_W-1:0]       brand;
   logic                     checksum_ok;
   logic [DIGIT_COUNT_W-1:0] digit_count;

   modport source (output valid, output brand, output checksum_ok, output digit_count,
                   input ready);
   modport sink   (input valid, input brand, input checksum_ok, input digit_count,
                   output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lcc_dabble.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Luhn card classifier binary to decimal unit
// Shift-and-add-three converter taking one input bit per cycle, which then
// rotates the decimal digits out one at a time, least significant first.
// ----------------------------------------------------------------------------
module lcc_dabble #(
   parameter int MAX_DIGITS = lcc_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic                      clock,
   input  lcc_pkg::dab_ctrl_type     ctrl,
   input  logic [lcc_pkg::CARD_W-1:0] value,
   output logic [3:0]                low_digit,
   output logic                      overflow
);
   import lcc_pkg::*;

   localparam int BCD_W = 4 * MAX_DIGITS;

   logic [CARD_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in;
   logic [BCD_W-1:0]  adj;
   logic              ovf_ff, ovf_in;

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      ovf_in = ovf_ff;
      if (ctrl.load) begin
         bin_in = value;
         bcd_in = '0;
         ovf_in = 1'b0;
      end else if (ctrl.shift) begin
         // A carry out of the top digit means the value needs more digits
         // than the register holds; the low digits stay correct regardless.
         bin_in = {bin_ff[CARD_W-2:0], 1'b0};
         bcd_in = {adj[BCD_W-2:0], bin_ff[CARD_W-1]};
         ovf_in = ovf_ff | adj[BCD_W-1];
      end else if (ctrl.rotate) begin
         bcd_in = {4'd0, bcd_ff[BCD_W-1:4]};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      ovf_ff <= ovf_in;
   end

   assign low_digit = bcd_ff[3:0];
   assign overflow  = ovf_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/lcc_digit_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Luhn card classifier digit accumulator
// Takes one decimal digit per cycle, keeps the Luhn sum modulo ten, the digit
// count and the two leading digits.
// ----------------------------------------------------------------------------
module lcc_digit_scan (
   input  logic                              clock,
   input  lcc_pkg::scan_ctrl_type            ctrl,
   input  logic [3:0]                        digit,
   input  logic [lcc_pkg::DIGIT_COUNT_W-1:0] index,
   output logic                              sum_zero,
   output logic [lcc_pkg::DIGIT_COUNT_W-1:0] count,
   output logic [3:0]                        top,
   output logic [3:0]                        next
);
   import lcc_pkg::*;

   logic [3:0]               sum_ff, sum_in;
   logic [DIGIT_COUNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]               top_ff, top_in;
   logic [3:0]               next_ff, next_in;
   logic [3:0]               prev_ff, prev_in;
   logic [3:0]               term;
   logic [4:0]               total;

   always_comb begin
      // Index zero is the rightmost place, which is added as it is.
      term  = index[0] ? luhn_double(digit) : digit;
      total = {1'b0, sum_ff} + {1'b0, term};
      if (total >= 5'd10) begin
         total = total - 5'd10;
      end

      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      top_in  = top_ff;
      next_in = next_ff;
      prev_in = prev_ff;
      if (ctrl.clear) begin
         sum_in  = 4'd0;
         cnt_in  = DIGIT_COUNT_W'(1);
         top_in  = 4'd0;
         next_in = 4'd0;
         prev_in = 4'd0;
      end else if (ctrl.step) begin
         sum_in  = total[3:0];
         prev_in = digit;
         // Leading zeros are scanned too, but only a non-zero digit moves
         // the most significant place.
         if (digit != 4'd0) begin
            cnt_in  = index + DIGIT_COUNT_W'(1);
            top_in  = digit;
            next_in = prev_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      cnt_ff  <= cnt_in;
      top_ff  <= top_in;
      next_ff <= next_in;
      prev_ff <= prev_in;
   end

   assign sum_zero = (sum_ff == 4'd0);
   assign count    = cnt_ff;
   assign top      = top_ff;
   assign next     = next_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/luhn_card_number_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Luhn card number classifier
// Converts a binary card number to decimal, forms the Luhn checksum and the
// digit count, and classifies the number by length and leading digits.
// ----------------------------------------------------------------------------
// A request runs through 63 single-bit conversion steps, then one digit scan
// step per decimal place, then the finish state, before its result is valid.
// No new request is taken until the previous one has left the finish state.
// A new request is taken while the previous result still waits on rsp.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// the result valid; no clearing pass is needed.
module luhn_card_number_classify #(
   parameter int MAX_DIGITS = lcc_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic      clock,
   input  logic      reset,
   lcc_req_if.sink   req_bus,
   lcc_rsp_if.source rsp_bus
);
   import lcc_pkg::*;

   localparam logic [STEP_W-1:0] LAST_BIT   = STEP_W'(CARD_W - 1);
   localparam logic [STEP_W-1:0] LAST_DIGIT = STEP_W'(MAX_DIGITS - 1);
   localparam logic [DIGIT_COUNT_W-1:0] FULL_COUNT = DIGIT_COUNT_W'(MAX_DIGITS);
   localparam logic [DIGIT_COUNT_W-1:0] LEN_13     = DIGIT_COUNT_W'(13);
   localparam logic [DIGIT_COUNT_W-1:0] LEN_15     = DIGIT_COUNT_W'(15);
   localparam logic [DIGIT_COUNT_W-1:0] LEN_16     = DIGIT_COUNT_W'(16);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                state_ff;
   logic [STEP_W-1:0]        step_ff;
   logic                     rsp_valid_ff;
   logic [BRAND_W-1:0]       brand_ff;
   logic                     ok_ff;
   logic [DIGIT_COUNT_W-1:0] count_ff;

   dab_ctrl_type             dab_ctrl;
   scan_ctrl_type            scan_ctrl;
   logic [3:0]               low_digit;
   logic                     overflow;
   logic                     sum_zero;
   logic [DIGIT_COUNT_W-1:0] scan_count;
   logic [3:0]               top;
   logic [3:0]               next;
   logic                     accept;
   logic                     rsp_free;
   logic [DIGIT_COUNT_W-1:0] count_in;
   logic [BRAND_W-1:0]       brand_in;

   assign accept   = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      dab_ctrl.load    = accept;
      dab_ctrl.shift   = (state_ff == ST_CONV);
      dab_ctrl.rotate  = (state_ff == ST_SCAN);
      scan_ctrl.clear  = accept;
      scan_ctrl.step   = (state_ff == ST_SCAN);
   end

   lcc_dabble #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dabble (
      .clock     (clock),
      .ctrl      (dab_ctrl),
      .value     (req_bus.pan),
      .low_digit (low_digit),
      .overflow  (overflow)
   );

   lcc_digit_scan u_scan (
      .clock    (clock),
      .ctrl     (scan_ctrl),
      .digit    (low_digit),
      .index    (step_ff[DIGIT_COUNT_W-1:0]),
      .sum_zero (sum_zero),
      .count    (scan_count),
      .top      (top),
      .next     (next)
   );

   always_comb begin
      count_in = overflow ? FULL_COUNT : scan_count;
      brand_in = BRAND_NONE;
      if (sum_zero && !overflow && (count_in >= DIGIT_COUNT_W'(2))) begin
         if (count_in == LEN_13 && top == 4'd4) begin
            brand_in = BRAND_PREFIX4;
         end else if (count_in == LEN_15 && top == 4'd3 &&
                      (next == 4'd4 || next == 4'd7)) begin
            brand_in = BRAND_PREFIX3X;
         end else if (count_in == LEN_16 && top == 4'd4) begin
            brand_in = BRAND_PREFIX4;
         end else if (count_in == LEN_16 && top == 4'd5 &&
                      next >= 4'd1 && next <= 4'd5) begin
            brand_in = BRAND_PREFIX5X;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_CONV;
                  step_ff  <= '0;
               end
            end
            ST_CONV: begin
               if (step_ff == LAST_BIT) begin
                  state_ff <= ST_SCAN;
                  step_ff  <= '0;
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            ST_SCAN: begin
               if (step_ff == LAST_DIGIT) begin
                  state_ff <= ST_FINISH;
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            ST_FINISH: begin
               // Hold the finished request here until the result register
               // is empty or is being emptied in this cycle.
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
                  brand_ff <= brand_in;
                  ok_ff    <= sum_zero;
                  count_ff <= count_in;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // A finished request refills the result register in the same cycle
         // that the waiting result leaves it.
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.brand       = brand_ff;
   assign rsp_bus.checksum_ok = ok_ff;
   assign rsp_bus.digit_count = count_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (count_ff >= DIGIT_COUNT_W'(1) && count_ff <= FULL_COUNT))
      else $error("digit count out of range");

   a_brand_needs_checksum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && brand_ff != BRAND_NONE) |-> ok_ff)
      else $error("brand given with a failed checksum");

   a_prefix4_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && brand_ff == BRAND_PREFIX4) |-> (count_ff == LEN_13 || count_ff == LEN_16))
      else $error("prefix-4 brand with a wrong length");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CONV && step_ff == '0))
      else $error("accepted request did not start conversion");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && step_ff == LAST_DIGIT) |=> (state_ff == ST_FINISH))
      else $error("digit scan did not end after the last digit");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/luhn_card_number_classify_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Luhn card number classifier checker
// Watches the request and result channels. For every accepted request it
// works out the digit count, the mod-10 checksum flag and the brand, and it
// compares each accepted result, in order, with the oldest of these.
// ----------------------------------------------------------------------------
module luhn_card_number_classify_checker #(
   parameter int MAX_DIGITS = lcc_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic clock,
   input  logic reset,
   lcc_req_if   req_mon,
   lcc_rsp_if   rsp_mon,
   output int   mismatches,
   output int   pending
);
   import lcc_pkg::*;

   typedef struct packed {
      logic [CARD_W-1:0]        card;
      logic [BRAND_W-1:0]       brand;
      logic                     checksum_ok;
      logic [DIGIT_COUNT_W-1:0] digit_count;
   } card_class_type;

   card_class_type expected_classes [$];
   int             error_total = 0;

   function automatic card_class_type classify_card(input logic [CARD_W-1:0] value);
      logic [CARD_W-1:0] rest;
      int unsigned       digit;
      int unsigned       doubled;
      int unsigned       luhn_sum;
      int unsigned       count;
      int unsigned       lead_hi;
      int unsigned       lead_lo;
      int unsigned       lead_pair;
      card_class_type    cls;
      rest     = value;
      luhn_sum = 0;
      count    = 0;
      lead_hi  = 0;
      lead_lo  = 0;
      // Digits are taken from the right; even places are doubled and folded.
      do begin
         digit = int'(rest % 10);
         rest  = rest / 10;
         count++;
         if (count % 2 == 1) begin
            luhn_sum += digit;
         end else begin
            doubled   = digit * 2;
            luhn_sum += doubled % 10 + doubled / 10;
         end
         lead_lo = lead_hi;
         lead_hi = digit;
      end while (rest != 0 && count < MAX_DIGITS);
      lead_pair       = lead_hi * 10 + lead_lo;
      cls.card        = value;
      cls.checksum_ok = (luhn_sum % 10 == 0);
      cls.digit_count = count[DIGIT_COUNT_W-1:0];
      cls.brand       = BRAND_NONE;
      if (cls.checksum_ok && rest == 0 && count >= 2) begin
         if ((count == 13 || count == 16) && lead_hi == 4) begin
            cls.brand = BRAND_PREFIX4;
         end else if (count == 15 && (lead_pair == 34 || lead_pair == 37)) begin
            cls.brand = BRAND_PREFIX3X;
         end else if (count == 16 && lead_pair >= 51 && lead_pair <= 55) begin
            cls.brand = BRAND_PREFIX5X;
         end
      end
      return cls;
   endfunction

   always @(posedge clock) begin
      card_class_type want;
      if (reset) begin
         expected_classes.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_classes.size() == 0) begin
               error_total++;
               if (error_total <= 10) begin
                  $display("unexpected result: brand %0d ok %0d digits %0d",
                           rsp_mon.brand, rsp_mon.checksum_ok, rsp_mon.digit_count);
               end
            end else begin
               want = expected_classes.pop_front();
               if (rsp_mon.brand !== want.brand || rsp_mon.checksum_ok !== want.checksum_ok
                   || rsp_mon.digit_count !== want.digit_count) begin
                  error_total++;
                  if (error_total <= 10) begin
                     $display("mismatch for card %0d: expected brand %0d ok %0d digits %0d,",
                              want.card, want.brand, want.checksum_ok, want.digit_count);
                     $display("   got brand %0d ok %0d digits %0d",
                              rsp_mon.brand, rsp_mon.checksum_ok, rsp_mon.digit_count);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_classes.push_back(classify_card(req_mon.pan));
         end
      end
      mismatches <= error_total;
      pending    <= expected_classes.size();
   end

endmodule
`default_nettype wire

FILE: tb/sv/luhn_card_number_classify_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Luhn card number classifier testbench
// Sends directed card numbers at the length and prefix boundaries, then a
// random mix weighted towards well-formed numbers of each brand, with random
// gaps on both channels and one long result hold-off that backs up requests.
// ----------------------------------------------------------------------------
module luhn_card_number_classify_tb;
   import lcc_pkg::*;

   localparam int RANDOM_CARDS = 850;
   localparam int CYCLE_LIMIT  = 1000000;

   logic clock;
   logic reset;
   logic hold_off;
   int   cycles    = 0;
   int   rsp_wait  = 0;
   int   accepted  = 0;
   int   mismatches;
   int   pending;

   lcc_req_if req_bus ();
   lcc_rsp_if rsp_bus ();

   luhn_card_number_classify u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   luhn_card_number_classify_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Mostly no gap or a short one, now and then a long one; none at all when quiet.
   function automatic int idle_gap(input bit quiet, input int long_max);
      int pick;
      pick = $urandom_range(99);
      if (quiet || pick < 55) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(4, 1);
      end
      return $urandom_range(long_max, 20);
   endfunction

   // Builds a number of the given length and leading digits whose check digit
   // is right when good is set and wrong otherwise.
   function automatic logic [CARD_W-1:0] make_card(input int len, input int lead,
                                                   input int lead_len, input bit good);
      int unsigned     dig [1:19];
      int unsigned     luhn_sum;
      int unsigned     doubled;
      longint unsigned value;
      int              pos;
      for (pos = 1; pos <= len; pos++) begin
         dig[pos] = $urandom_range(9);
      end
      if (lead_len == 2) begin
         dig[len]     = lead / 10;
         dig[len - 1] = lead % 10;
      end else if (lead_len == 1) begin
         dig[len] = lead;
      end
      if (len > 1 && dig[len] == 0) begin
         dig[len] = 1;
      end
      if (len == 19 && dig[19] > 8) begin
         dig[19] = 8;
      end
      luhn_sum = 0;
      for (pos = 2; pos <= len; pos++) begin
         if (pos % 2 == 0) begin
            doubled   = dig[pos] * 2;
            luhn_sum += doubled % 10 + doubled / 10;
         end else begin
            luhn_sum += dig[pos];
         end
      end
      dig[1] = (10 - luhn_sum % 10) % 10;
      if (!good) begin
         dig[1] = (dig[1] + $urandom_range(9, 1)) % 10;
      end
      value = 0;
      for (pos = len; pos >= 1; pos--) begin
         value = value * 10 + dig[pos];
      end
      return value[CARD_W-1:0];
   endfunction

   // One request per call; valid stays high across back-to-back requests.
   task automatic send_card(input logic [CARD_W-1:0] value, input bit quiet);
      int gap;
      gap = idle_gap(quiet, 60);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         req_bus.pan   <= CARD_W'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pan   <= value;
      do @(posedge clock); while (!req_bus.ready);
      accepted++;
   endtask

   task automatic send_branded(input bit good, input bit quiet);
      case ($urandom_range(3))
         0: send_card(make_card(13, 4, 1, good), quiet);
         1: send_card(make_card(16, 4, 1, good), quiet);
         2: send_card(make_card(15, $urandom_range(1) ? 34 : 37, 2, good), quiet);
         default: send_card(make_card(16, $urandom_range(55, 51), 2, good), quiet);
      endcase
   endtask

   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait      <= 0;
      end else if (hold_off) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait      <= rsp_wait - 1;
      end else begin
         gap           = idle_gap((cycles / 3000) % 3 == 0, 150);
         rsp_bus.ready <= (gap == 0);
         rsp_wait      <= gap;
      end
   end

   // Holds the result channel off long enough for requests to back up.
   initial begin
      hold_off <= 1'b0;
      while (accepted < 300) @(posedge clock);
      hold_off <= 1'b1;
      repeat (1500) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      int idx;
      int pick;
      int len;
      bit quiet;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.pan   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero, single digits, the largest value and length boundaries.
      send_card('0, 1'b0);
      send_card(63'd7, 1'b0);
      send_card(63'd9, 1'b0);
      send_card(63'd18, 1'b0);
      send_card(63'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      send_card(63'd1000000000000000000, 1'b0);
      send_card(CARD_W'({$urandom, $urandom}) ^ 63'h5555_5555_5555_5555, 1'b0);
      // Every brand, at the ends of each prefix range.
      send_card(make_card(13, 4, 1, 1'b1), 1'b0);
      send_card(make_card(16, 4, 1, 1'b1), 1'b0);
      send_card(make_card(15, 34, 2, 1'b1), 1'b0);
      send_card(make_card(15, 37, 2, 1'b1), 1'b0);
      send_card(make_card(16, 51, 2, 1'b1), 1'b0);
      send_card(make_card(16, 55, 2, 1'b1), 1'b0);
      // Near misses: a bad check digit, a wrong length or a prefix just outside.
      send_card(make_card(13, 4, 1, 1'b0), 1'b0);
      send_card(make_card(16, 52, 2, 1'b0), 1'b0);
      send_card(make_card(16, 50, 2, 1'b1), 1'b0);
      send_card(make_card(16, 56, 2, 1'b1), 1'b0);
      send_card(make_card(15, 35, 2, 1'b1), 1'b0);
      send_card(make_card(15, 4, 1, 1'b1), 1'b0);
      send_card(make_card(14, 4, 1, 1'b1), 1'b0);
      send_card(make_card(12, 4, 1, 1'b1), 1'b0);
      send_card(make_card(17, 4, 1, 1'b1), 1'b0);
      send_card(make_card(13, 34, 2, 1'b1), 1'b0);
      send_card(make_card(19, 4, 1, 1'b1), 1'b0);

      for (idx = 0; idx < RANDOM_CARDS; idx++) begin
         quiet = ((idx / 96) % 4 == 3);
         pick  = $urandom_range(99);
         if (pick < 45) begin
            send_branded(1'b1, quiet);
         end else if (pick < 60) begin
            send_branded(1'b0, quiet);
         end else if (pick < 70) begin
            len = $urandom_range(18, 2);
            send_card(make_card(len, $urandom_range(1) ? 4 : $urandom_range(55, 34),
                                $urandom_range(1) ? 1 : 2, 1'b1), quiet);
         end else if (pick < 80) begin
            send_card(make_card($urandom_range(16, 13), $urandom_range(99, 10), 2, 1'b1),
                      quiet);
         end else if (pick < 90) begin
            send_card(make_card($urandom_range(19, 1), 0, 0, $urandom_range(1)), quiet);
         end else begin
            send_card(CARD_W'({$urandom, $urandom}), quiet);
         end
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/lcc_pkg.sv
hw/rtl/lcc_channels.sv
hw/rtl/lcc_dabble.sv
hw/rtl/lcc_digit_scan.sv
hw/rtl/luhn_card_number_classify.sv
tb/sv/luhn_card_number_classify_checker.sv
tb/sv/luhn_card_number_classify_tb.sv
